@@ design/rhc_pkg.sv @@
// shared constants, types and the divider step for the rgb to hsv converter
package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS = 16;

    localparam int SPAN_W = CHANNEL_BITS + 3;
    localparam int SATNUM_W = 2 * CHANNEL_BITS;

    localparam int DIV_STAGES = 8;
    localparam int HUE_STEPS = (HUE_BITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int SAT_STEPS = (CHANNEL_BITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int STAGE_STEPS = (HUE_STEPS > SAT_STEPS) ? HUE_STEPS : SAT_STEPS;

    localparam int PIPE_LATENCY = DIV_STAGES + 3;

    typedef struct packed {
        logic [SPAN_W-1:0]       hrem;
        logic [HUE_BITS-1:0]     hquo;
        logic [SPAN_W-1:0]       span;
        logic [CHANNEL_BITS-1:0] srem;
        logic [CHANNEL_BITS-1:0] slo;
        logic [CHANNEL_BITS-1:0] squo;
        logic [CHANNEL_BITS-1:0] value;
        logic [CHANNEL_BITS-1:0] alpha;
        logic                    grey;
    } div_t;

    // one restoring step of each division lane
    function automatic div_t div_step(div_t d, logic do_hue, logic do_sat);
        logic [SPAN_W:0]       ht;
        logic [CHANNEL_BITS:0] st;
        div_t                  q;
        q  = d;
        ht = '0;
        st = '0;
        if (do_hue)
        begin
            ht = {d.hrem, 1'b0};
            if (ht >= {1'b0, d.span})
            begin
                ht     = ht - {1'b0, d.span};
                q.hquo = {d.hquo[HUE_BITS-2:0], 1'b1};
            end
            else
            begin
                q.hquo = {d.hquo[HUE_BITS-2:0], 1'b0};
            end
            q.hrem = ht[SPAN_W-1:0];
        end
        if (do_sat)
        begin
            st = {d.srem, d.slo[CHANNEL_BITS-1]};
            if (st >= {1'b0, d.value})
            begin
                st     = st - {1'b0, d.value};
                q.squo = {d.squo[CHANNEL_BITS-2:0], 1'b1};
            end
            else
            begin
                q.squo = {d.squo[CHANNEL_BITS-2:0], 1'b0};
            end
            q.srem = st[CHANNEL_BITS-1:0];
            q.slo  = {d.slo[CHANNEL_BITS-2:0], 1'b0};
        end
        return q;
    endfunction

endpackage

@@ design/rhc_div.sv @@
// pipelined restoring divider for hue and saturation lanes
module rhc_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  rhc_pkg::div_t in_data,
    output logic          out_valid,
    output rhc_pkg::div_t out_data
);
    import rhc_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    div_t                  data_reg  [DIV_STAGES];
    div_t                  data_next [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        always_comb
        begin
            div_t d;
            d = (s == 0) ? in_data : data_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < STAGE_STEPS; j++)
            begin
                d = div_step(d,
                             (j < HUE_STEPS) && (s * HUE_STEPS + j < HUE_BITS),
                             (j < SAT_STEPS) && (s * SAT_STEPS + j < CHANNEL_BITS));
            end
            data_next[s] = d;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            data_reg[s] <= data_next[s];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_data  = data_reg[DIV_STAGES-1];

endmodule

@@ design/rgb_to_hsv_pixel_converter.sv @@
// rgb to hsv pixel converter top level
//
//  channel  | handshake          | fields
//  ---------+--------------------+----------------------------------------
//  pixel in | start, busy        | red, green, blue, alpha
//  result   | done (one cycle)   | hue, saturation, brightness, opacity
//
// one pixel per cycle; busy stays low, a new pixel may start every cycle
// each result passes through two front stages, eight stages of the pipelined divider
// and one output register
// the divider stages (two hue bits and one saturation bit each) set the latency
// reset clears all valid bits; pixels in flight are dropped
// the receiver cannot stall, so nothing ever holds the pipeline
module rgb_to_hsv_pixel_converter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] red,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] green,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] blue,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] alpha,
    output logic                             done,
    output logic [rhc_pkg::HUE_BITS-1:0]     hue,
    output logic [rhc_pkg::CHANNEL_BITS-1:0] saturation,
    output logic [rhc_pkg::CHANNEL_BITS-1:0] brightness,
    output logic [rhc_pkg::CHANNEL_BITS-1:0] opacity
);
    import rhc_pkg::*;

    typedef enum logic [1:0] {
        SECT_RED   = 2'b00,
        SECT_GREEN = 2'b01,
        SECT_BLUE  = 2'b10
    } sector_t;

    logic                    accept;

    logic [CHANNEL_BITS-1:0] hi_next;
    logic [CHANNEL_BITS-1:0] lo_next;
    sector_t                 sector_next;

    logic                    s1_valid_reg;
    logic [CHANNEL_BITS-1:0] s1_red_reg;
    logic [CHANNEL_BITS-1:0] s1_green_reg;
    logic [CHANNEL_BITS-1:0] s1_blue_reg;
    logic [CHANNEL_BITS-1:0] s1_alpha_reg;
    logic [CHANNEL_BITS-1:0] s1_hi_reg;
    logic [CHANNEL_BITS-1:0] s1_chroma_reg;
    sector_t                 s1_sector_reg;

    logic [SPAN_W-1:0]       span;
    logic [SPAN_W-1:0]       num;
    logic [SATNUM_W-1:0]     satnum;
    div_t                    s2_data_next;

    logic                    s2_valid_reg;
    div_t                    s2_data_reg;

    logic                    div_valid;
    div_t                    div_data;

    logic                    done_reg;
    logic [HUE_BITS-1:0]     hue_reg;
    logic [CHANNEL_BITS-1:0] saturation_reg;
    logic [CHANNEL_BITS-1:0] brightness_reg;
    logic [CHANNEL_BITS-1:0] opacity_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // max, min and sector with red winning ties, then green
    always_comb
    begin
        hi_next = red;
        lo_next = red;
        if (green > hi_next)
        begin
            hi_next = green;
        end
        if (blue > hi_next)
        begin
            hi_next = blue;
        end
        if (green < lo_next)
        begin
            lo_next = green;
        end
        if (blue < lo_next)
        begin
            lo_next = blue;
        end
        priority if (hi_next == red)
        begin
            sector_next = SECT_RED;
        end
        else if (hi_next == green)
        begin
            sector_next = SECT_GREEN;
        end
        else
        begin
            sector_next = SECT_BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_red_reg    <= red;
        s1_green_reg  <= green;
        s1_blue_reg   <= blue;
        s1_alpha_reg  <= alpha;
        s1_hi_reg     <= hi_next;
        s1_chroma_reg <= hi_next - lo_next;
        s1_sector_reg <= sector_next;
    end

    // numerator of the hue fraction, kept in [0, 6c), with its divisor 6c and the saturation numerator 255c
    always_comb
    begin
        span   = (SPAN_W'(s1_chroma_reg) << 2) + (SPAN_W'(s1_chroma_reg) << 1);
        satnum = (SATNUM_W'(s1_chroma_reg) << CHANNEL_BITS) - SATNUM_W'(s1_chroma_reg);
        unique case (s1_sector_reg)
            SECT_RED:
            begin
                if (s1_green_reg >= s1_blue_reg)
                begin
                    num = SPAN_W'(s1_green_reg - s1_blue_reg);
                end
                else
                begin
                    num = span - SPAN_W'(s1_blue_reg - s1_green_reg);
                end
            end
            SECT_GREEN:
            begin
                num = (SPAN_W'(s1_chroma_reg) << 1) + SPAN_W'(s1_blue_reg)
                      - SPAN_W'(s1_red_reg);
            end
            SECT_BLUE:
            begin
                num = (SPAN_W'(s1_chroma_reg) << 2) + SPAN_W'(s1_red_reg)
                      - SPAN_W'(s1_green_reg);
            end
            default:
            begin
                num = '0;
            end
        endcase
        s2_data_next.hrem  = num;
        s2_data_next.hquo  = '0;
        s2_data_next.span  = span;
        s2_data_next.srem  = satnum[SATNUM_W-1:CHANNEL_BITS];
        s2_data_next.slo   = satnum[CHANNEL_BITS-1:0];
        s2_data_next.squo  = '0;
        s2_data_next.value = s1_hi_reg;
        s2_data_next.alpha = s1_alpha_reg;
        s2_data_next.grey  = (s1_chroma_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_data_reg <= s2_data_next;
    end

    rhc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_data   (s2_data_reg),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    // grey pixels have no hue and no saturation
    always_ff @(posedge clk)
    begin
        hue_reg        <= div_data.grey ? '0 : div_data.hquo;
        saturation_reg <= div_data.grey ? '0 : div_data.squo;
        brightness_reg <= div_data.value;
        opacity_reg    <= div_data.alpha;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = saturation_reg;
    assign brightness = brightness_reg;
    assign opacity    = opacity_reg;

endmodule

@@ design/rhc_checker.sv @@
// port-level checker for the rgb to hsv converter and its bind
module rhc_port_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [rhc_pkg::CHANNEL_BITS-1:0] alpha,
    input logic                             done,
    input logic [rhc_pkg::HUE_BITS-1:0]     hue,
    input logic [rhc_pkg::CHANNEL_BITS-1:0] saturation,
    input logic [rhc_pkg::CHANNEL_BITS-1:0] brightness,
    input logic [rhc_pkg::CHANNEL_BITS-1:0] opacity
);
    import rhc_pkg::*;

    localparam int AGE_W = $clog2(PIPE_LATENCY + 1);

    logic [AGE_W-1:0] age_reg;
    logic             aged;

    assign aged = (age_reg == AGE_W'(PIPE_LATENCY));

    // cycles since reset release, saturating at the pipeline latency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else if (!aged)
        begin
            age_reg <= age_reg + 1'b1;
        end
    end

    // every transaction gives exactly one result after the pipeline latency
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        aged |-> (done == $past(start && !busy, PIPE_LATENCY)))
        else $error("result strobe does not match accepted transaction");

    a_alpha_through: assert property (@(posedge clk) disable iff (!rst_n)
        (aged && done) |-> (opacity == $past(alpha, PIPE_LATENCY)))
        else $error("opacity does not match alpha of its transaction");

    // black pixels have neither hue nor saturation
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && brightness == '0) |-> (hue == '0 && saturation == '0))
        else $error("black pixel with hue or saturation");

    // zero saturation only for grey, which has zero hue
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturation == '0) |-> (hue == '0))
        else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_pixel_converter rhc_port_checker u_rhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .alpha      (alpha),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .opacity    (opacity)
);
